[rtl/core/eva_pkg.sv]
// -----------------------------------------------------------------------------
// eva_pkg
// Shared widths, constants and sequencer states of the ensemble vote
// aggregator.
// -----------------------------------------------------------------------------
`default_nettype none

package eva_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned NUM_CATEGORIES_DEF = 16;
  localparam int unsigned MAX_TREES_DEF      = 1024;

  // Field widths of the transactions
  localparam int unsigned CAT_W    = 4;
  localparam int unsigned PROB_W   = 17;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned VOTES_W  = 11;

  // Accumulator and product widths
  localparam int unsigned PWS_W  = 43;
  localparam int unsigned WT_W   = 26;
  localparam int unsigned PROD_W = PROB_W + WEIGHT_W;

  // Divider: quotient bits cover one overflow bit above the 17-bit mean
  localparam int unsigned QUO_W  = PROB_W + 1;
  localparam int unsigned STEP_W = $clog2(QUO_W);

  // Probability of one in Q16
  localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(65536);

  // Largest value the winning vote count port can carry
  localparam logic [VOTES_W-1:0] VOTES_OUT_MAX = '1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_SCAN,
    ST_DIV,
    ST_FIN
  } eva_state_e;

endpackage

`default_nettype wire

[rtl/core/ensemble_vote_aggregator_top.sv]
// -----------------------------------------------------------------------------
// ensemble_vote_aggregator_top
// Majority vote over the trees of a forest with a weighted mean probability.
// Sequencing: a vote that is not last is accepted in ST_IDLE and its count
//   updated in ST_UPD, limited by the read-modify-write of the vote count
//   memory; no new vote is accepted until the sequencer is back in ST_IDLE.
// A last vote then runs the argmax scan over that memory and the restoring
//   divider, then waits in ST_FIN until the output register is free to load it.
// Reset clears all counts (per-entry valid bits), both sums and the result valid flag.
// -----------------------------------------------------------------------------
`default_nettype none

module ensemble_vote_aggregator_top #(
  parameter int unsigned NUM_CATEGORIES = eva_pkg::NUM_CATEGORIES_DEF,
  parameter int unsigned MAX_TREES      = eva_pkg::MAX_TREES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic [eva_pkg::CAT_W-1:0]     category_i,
  input  wire logic [eva_pkg::PROB_W-1:0]    tree_prob_i,
  input  wire logic [eva_pkg::WEIGHT_W-1:0]  tree_weight_i,
  input  wire logic                          last_vote_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [eva_pkg::CAT_W-1:0]     winning_category_o,
  output      logic [eva_pkg::PROB_W-1:0]    mean_prob_o,
  output      logic [eva_pkg::VOTES_W-1:0]   winning_votes_o
);

  import eva_pkg::*;

  localparam int unsigned IW    = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;
  localparam int unsigned SW    = IW + 1;
  localparam int unsigned CNT_W = $clog2(MAX_TREES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_TREES);
  localparam logic [SW-1:0]    SCAN_END  = SW'(NUM_CATEGORIES);
  localparam logic [STEP_W-1:0] STEP_TOP = STEP_W'(QUO_W - 1);

  // Sequencer
  eva_state_e state_q, state_d;

  // Vote count memory with per-entry valid bits
  logic [CNT_W-1:0]          cnt_mem [NUM_CATEGORIES];
  logic [NUM_CATEGORIES-1:0] vld_q, vld_d;
  logic                      rd_en;
  logic [IW-1:0]             rd_addr;
  logic [CNT_W-1:0]          rd_q;
  logic                      rdv_q;
  logic                      wr_en;
  logic [CNT_W-1:0]          wr_data;
  logic [CNT_W-1:0]          cnt_cur;

  // Registered vote
  logic [IW-1:0]       cat_q;
  logic                cat_ok_q;
  logic [PROD_W-1:0]   prod_q;
  logic [WEIGHT_W-1:0] wt_in_q;
  logic                last_q;
  logic                in_acc;
  logic                cat_ok_in;
  logic [PROB_W-1:0]   prob_clip;

  // Accumulators
  logic [PWS_W-1:0] pws_q, pws_d;
  logic [WT_W-1:0]  wt_q, wt_d;
  logic [PWS_W:0]   pws_sum;
  logic [WT_W:0]    wt_sum;

  // Argmax scan
  logic [SW-1:0]    scan_q, scan_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IW-1:0]    cmp_idx_q, cmp_idx_d;
  logic [IW-1:0]    best_idx_q, best_idx_d;
  logic [CNT_W-1:0] best_cnt_q, best_cnt_d;

  // Restoring divider
  logic [PWS_W-1:0]  rem_q, rem_d;
  logic [PWS_W:0]    den_q, den_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              div_ge;

  // Output register
  logic               out_vld_q, out_vld_d;
  logic               out_free;
  logic               out_load;
  logic [CAT_W-1:0]   win_cat_q;
  logic [PROB_W-1:0]  mean_q, mean_res;
  logic [VOTES_W-1:0] win_votes_q, votes_res;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_vld_q || out_ready_i;

  assign cat_ok_in = (32'(category_i) < NUM_CATEGORIES);
  assign prob_clip = (tree_prob_i > PROB_ONE) ? PROB_ONE : tree_prob_i;

  assign cnt_cur = rdv_q ? rd_q : '0;
  assign pws_sum = {1'b0, pws_q} + (PWS_W + 1)'(prod_q);
  assign wt_sum  = {1'b0, wt_q} + (WT_W + 1)'(wt_in_q);
  assign div_ge  = ({1'b0, rem_q} >= den_q);

  // Clamp the quotient to one (zero for a zero weight sum) and the count to the port width
  assign mean_res  = (wt_q == '0) ? '0 :
                     ((quo_q > QUO_W'(PROB_ONE)) ? PROB_ONE : quo_q[PROB_W-1:0]);
  assign votes_res = (32'(best_cnt_q) > 32'(VOTES_OUT_MAX)) ? VOTES_OUT_MAX
                                                            : VOTES_W'(best_cnt_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_UPD;
      end
      ST_UPD: begin
        state_d = last_q ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_q == SCAN_END && !cmp_vld_q) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (step_q == '0) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath control and next values
  always_comb begin
    rd_en      = 1'b0;
    rd_addr    = IW'(category_i);
    wr_en      = 1'b0;
    wr_data    = (cnt_cur < CNT_MAX) ? cnt_cur + 1'b1 : cnt_cur;
    vld_d      = vld_q;
    pws_d      = pws_q;
    wt_d       = wt_q;
    scan_d     = scan_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    best_idx_d = best_idx_q;
    best_cnt_d = best_cnt_q;
    rem_d      = rem_q;
    den_d      = den_q;
    quo_d      = quo_q;
    step_d     = step_q;
    out_load   = 1'b0;
    out_vld_d  = out_vld_q && !out_ready_i;

    case (state_q)
      ST_IDLE: begin
        // Fetch the current count of the voted category
        rd_en = in_acc && cat_ok_in;
      end
      ST_UPD: begin
        // Write back the saturated count, add to both sums
        wr_en = cat_ok_q;
        if (cat_ok_q) vld_d[cat_q] = 1'b1;
        pws_d = pws_sum[PWS_W] ? '1 : pws_sum[PWS_W-1:0];
        wt_d  = wt_sum[WT_W] ? '1 : wt_sum[WT_W-1:0];
        // Arm the scan
        scan_d     = '0;
        best_idx_d = '0;
        best_cnt_d = '0;
      end
      ST_SCAN: begin
        // Issue one read a cycle, compare the one that returns
        if (scan_q != SCAN_END) begin
          rd_en     = 1'b1;
          rd_addr   = scan_q[IW-1:0];
          scan_d    = scan_q + 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = scan_q[IW-1:0];
        end
        if (cmp_vld_q && (cnt_cur > best_cnt_q)) begin
          best_idx_d = cmp_idx_q;
          best_cnt_d = cnt_cur;
        end
        // Load the divider for the first step
        rem_d  = pws_q;
        den_d  = {1'b0, wt_q, {(PWS_W - WT_W){1'b0}}} << (QUO_W - 1 - (PWS_W - WT_W));
        quo_d  = '0;
        step_d = STEP_TOP;
      end
      ST_DIV: begin
        // One quotient bit a cycle
        if (div_ge) rem_d = rem_q - den_q[PWS_W-1:0];
        quo_d  = {quo_q[QUO_W-2:0], div_ge};
        den_d  = den_q >> 1;
        step_d = step_q - 1'b1;
      end
      ST_FIN: begin
        // Hand over the result and clear the event state
        if (out_free) begin
          out_load  = 1'b1;
          out_vld_d = 1'b1;
          vld_d     = '0;
          pws_d     = '0;
          wt_d      = '0;
        end
      end
      default: begin
        vld_d = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      vld_q     <= '0;
      pws_q     <= '0;
      wt_q      <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      vld_q     <= vld_d;
      pws_q     <= pws_d;
      wt_q      <= wt_d;
      cmp_vld_q <= cmp_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Vote count memory
  always_ff @(posedge clk_i) begin
    if (wr_en) cnt_mem[cat_q] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q  <= cnt_mem[rd_addr];
      rdv_q <= vld_q[rd_addr];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cat_q    <= IW'(category_i);
      cat_ok_q <= cat_ok_in;
      prod_q   <= PROD_W'(prob_clip) * PROD_W'(tree_weight_i);
      wt_in_q  <= tree_weight_i;
      last_q   <= last_vote_i;
    end
    scan_q     <= scan_d;
    cmp_idx_q  <= cmp_idx_d;
    best_idx_q <= best_idx_d;
    best_cnt_q <= best_cnt_d;
    rem_q      <= rem_d;
    den_q      <= den_d;
    quo_q      <= quo_d;
    step_q     <= step_d;
    if (out_load) begin
      win_cat_q   <= CAT_W'(best_idx_q);
      mean_q      <= mean_res;
      win_votes_q <= votes_res;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign winning_category_o = win_cat_q;
  assign mean_prob_o        = mean_q;
  assign winning_votes_o    = win_votes_q;

  // Assertions
  a_load_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_FIN)
    else $error("result appeared outside the final step");

  a_mean_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> mean_prob_o <= PROB_ONE)
    else $error("mean probability above one");

  a_clear_after_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_free) |=> (vld_q == '0 && pws_q == '0 && wt_q == '0))
    else $error("event state not cleared after the result");

  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && state_d == ST_DIV) |=> ##(QUO_W) state_q == ST_FIN)
    else $error("divider did not finish in its step count");

endmodule

`default_nettype wire

[tb/tb_ensemble_vote_aggregator_top.sv]
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_ensemble_vote_aggregator_top
// Drives forest votes into the aggregator and predicts every event result:
// per-category vote counts with saturation, the clamped weighted probability
// sum and the weight sum, then the argmax with lowest-index tie break and the
// truncated mean. Runs directed corner events, then random events under
// several sender/receiver idle mixes, including one event long enough to
// saturate the vote count and the weight sum.
// -----------------------------------------------------------------------------

module tb_ensemble_vote_aggregator_top;
  import eva_pkg::*;

  localparam int unsigned NUM_CATS     = NUM_CATEGORIES_DEF;
  localparam int unsigned MAX_VOTES    = MAX_TREES_DEF;
  localparam int unsigned PHASE_VOTES  = 170;
  localparam int unsigned FLOOD_VOTES  = 1060;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT  = 500_000;

  typedef struct packed {
    logic [CAT_W-1:0]   category;
    logic [PROB_W-1:0]  mean;
    logic [VOTES_W-1:0] votes;
  } vote_result_t;

  // Tracks the running tallies of the open event and the results still owed
  class vote_tally;
    logic [VOTES_W-1:0] vote_count [NUM_CATS];
    logic [PWS_W-1:0]   prob_weight_acc;
    logic [WT_W-1:0]    weight_acc;
    vote_result_t       expected_q [$];
    int unsigned        mismatches;

    function new();
      mismatches = 0;
      clear_tallies();
    endfunction

    function void clear_tallies();
      foreach (vote_count[i]) vote_count[i] = '0;
      prob_weight_acc = '0;
      weight_acc      = '0;
    endfunction

    // Add one accepted vote; on the last vote close the event
    function void note_vote(logic [CAT_W-1:0] cat, logic [PROB_W-1:0] prob,
                            logic [WEIGHT_W-1:0] weight, logic last_vote);
      logic [PROB_W-1:0] p;
      logic [PWS_W:0]    pws_next;
      logic [WT_W:0]     wt_next;
      logic [PWS_W-1:0]  quo;
      int unsigned       best;
      vote_result_t      r;
      p = (prob > PROB_ONE) ? PROB_ONE : prob;
      if (cat < NUM_CATS && vote_count[cat] < MAX_VOTES) vote_count[cat]++;
      pws_next = (PWS_W+1)'(prob_weight_acc) + (PWS_W+1)'(p) * (PWS_W+1)'(weight);
      prob_weight_acc = pws_next[PWS_W] ? '1 : pws_next[PWS_W-1:0];
      wt_next = (WT_W+1)'(weight_acc) + (WT_W+1)'(weight);
      weight_acc = wt_next[WT_W] ? '1 : wt_next[WT_W-1:0];
      if (!last_vote) return;
      // Strict compare keeps the lowest index on a tie
      best = 0;
      for (int i = 1; i < NUM_CATS; i++) begin
        if (vote_count[i] > vote_count[best]) best = i;
      end
      quo = (weight_acc == '0) ? '0 : prob_weight_acc / PWS_W'(weight_acc);
      r.category = CAT_W'(best);
      r.mean     = (quo > PWS_W'(PROB_ONE)) ? PROB_ONE : quo[PROB_W-1:0];
      r.votes    = vote_count[best];
      expected_q.push_back(r);
      clear_tallies();
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] vote mismatch: %s", $time, msg);
      mismatches++;
    endtask

    // Compare one accepted result against the oldest pending event
    task check_result(logic [CAT_W-1:0] cat, logic [PROB_W-1:0] mean,
                      logic [VOTES_W-1:0] votes);
      vote_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with no event pending (cat %0d)", cat));
        return;
      end
      want = expected_q.pop_front();
      if (cat !== want.category)
        report_mismatch($sformatf("winning_category %0d, want %0d", cat, want.category));
      if (mean !== want.mean)
        report_mismatch($sformatf("mean_prob %0d, want %0d", mean, want.mean));
      if (votes !== want.votes)
        report_mismatch($sformatf("winning_votes %0d, want %0d", votes, want.votes));
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [CAT_W-1:0]    category_i    = '0;
  logic [PROB_W-1:0]   tree_prob_i   = '0;
  logic [WEIGHT_W-1:0] tree_weight_i = '0;
  logic                last_vote_i   = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic [CAT_W-1:0]    winning_category_o;
  logic [PROB_W-1:0]   mean_prob_o;
  logic [VOTES_W-1:0]  winning_votes_o;

  vote_tally   tally = new();
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned votes_sent     = 0;
  int unsigned cycle_count    = 0;

  ensemble_vote_aggregator_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .category_i         (category_i),
    .tree_prob_i        (tree_prob_i),
    .tree_weight_i      (tree_weight_i),
    .last_vote_i        (last_vote_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .winning_category_o (winning_category_o),
    .mean_prob_o        (mean_prob_o),
    .winning_votes_o    (winning_votes_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Sample results and pick the next ready level at each edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      tally.check_result(winning_category_o, mean_prob_o, winning_votes_o);
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Present one vote, hold it until accepted, then note it
  task automatic send_vote(logic [CAT_W-1:0] cat, logic [PROB_W-1:0] prob,
                           logic [WEIGHT_W-1:0] weight, logic last_vote);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    category_i    <= cat;
    tree_prob_i   <= prob;
    tree_weight_i <= weight;
    last_vote_i   <= last_vote;
    do @(posedge clk_i); while (!in_ready_o);
    tally.note_vote(cat, prob, weight, last_vote);
    votes_sent++;
  endtask

  // One event of random length and content
  task automatic send_random_event();
    int unsigned         len;
    int unsigned         cat_hi;
    bit                  zero_weights;
    logic [PROB_W-1:0]   prob;
    logic [WEIGHT_W-1:0] weight;
    case ($urandom_range(0, 19))
      0:           len = 1;
      1, 2, 3, 4:  len = $urandom_range(7, 30);
      default:     len = $urandom_range(2, 6);
    endcase
    // Narrow category range forces frequent ties
    cat_hi       = ($urandom_range(0, 2) == 0) ? 2 : NUM_CATS - 1;
    zero_weights = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0:       prob = PROB_W'($urandom_range(65537, 131071));
        1:       prob = ($urandom_range(0, 1) == 0) ? '0 : PROB_ONE;
        default: prob = PROB_W'($urandom_range(0, 65536));
      endcase
      case ($urandom_range(0, 9))
        0:       weight = '0;
        1:       weight = '1;
        default: weight = WEIGHT_W'($urandom);
      endcase
      if (zero_weights) weight = '0;
      send_vote(CAT_W'($urandom_range(0, cat_hi)), prob, weight, i == len - 1);
    end
  endtask

  initial begin
    int unsigned phase_start;
    int unsigned flood_cat;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero weight sum, probability of exactly one at full weight
    send_vote(4'd0, '0, '0, 1'b1);
    send_vote(4'd15, PROB_ONE, 16'hFFFF, 1'b1);
    // Probability above one gets clamped
    send_vote(4'd6, 17'h1FFFF, 16'h0100, 1'b0);
    send_vote(4'd6, 17'h10001, 16'h0001, 1'b1);
    // Two-way tie resolves to the lower index; toggle every probability and weight bit
    send_vote(4'd9, 17'h0AAAA, 16'hAAAA, 1'b0);
    send_vote(4'd3, 17'h15555, 16'h5555, 1'b0);
    send_vote(4'd9, 17'h00001, 16'h0002, 1'b0);
    send_vote(4'd3, 17'h00002, 16'h0001, 1'b1);
    // All-zero weights in a multi-vote event
    send_vote(4'd7, 17'd1000, '0, 1'b0);
    send_vote(4'd12, PROB_ONE, '0, 1'b1);
    // Mean truncates toward zero: 5 / 3
    send_vote(4'd1, 17'd1, 16'd1, 1'b0);
    send_vote(4'd1, 17'd2, 16'd2, 1'b1);

    // Random events under four idle mixes
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      phase_start = votes_sent;
      if (phase == 0) begin
        // Flood one category past the vote cap at full weight so the count,
        // the weight sum and the mean all saturate
        flood_cat = $urandom_range(0, NUM_CATS - 1);
        for (int i = 0; i < FLOOD_VOTES; i++)
          send_vote(CAT_W'((i < NUM_CATS) ? i : flood_cat),
                    PROB_W'($urandom_range(65536, 131071)), '1, i == FLOOD_VOTES - 1);
        phase_start = votes_sent;
      end
      while (votes_sent - phase_start < PHASE_VOTES) send_random_event();
    end
    in_valid_i <= 1'b0;

    // Drain outstanding events, then give the block time to misbehave
    while (tally.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tally.expected_q.size() != 0)
      tally.report_mismatch($sformatf("%0d results never arrived", tally.expected_q.size()));
    if (tally.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[files.f]
rtl/core/eva_pkg.sv
rtl/core/ensemble_vote_aggregator_top.sv
tb/tb_ensemble_vote_aggregator_top.sv
